// ===== hdl/two_stacks_shared_array_core_defines.svh =====
// Assertion macros shared by the two-stack core.
`ifndef TWO_STACKS_SHARED_ARRAY_CORE_DEFINES_SVH
`define TWO_STACKS_SHARED_ARRAY_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tssa_pkg.sv =====
// Package with the types, sizes and codes of the two-stack core.
`timescale 1ns / 1ps
package tssa_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  localparam logic [2:0] OP_PUSH_ONE  = 3'd0;
  localparam logic [2:0] OP_PUSH_TWO  = 3'd1;
  localparam logic [2:0] OP_POP_ONE   = 3'd2;
  localparam logic [2:0] OP_POP_TWO   = 3'd3;
  localparam logic [2:0] OP_DRAIN_ONE = 3'd4;
  localparam logic [2:0] OP_DRAIN_TWO = 3'd5;

  localparam logic [1:0] ST_PUSH_DONE = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_POPPED    = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam logic signed [WORD_W-1:0] MINUS_ONE = '1;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [WORD_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [1:0]               status_code;
    logic                     last_of_run;
    logic                     store_full;
    logic                     both_empty;
  } out_item_t;

endpackage

// ===== hdl/tssa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module tssa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/two_stacks_shared_array_core.sv =====
// Top level of the two-stack core: control, stack counts and output register.
//
// Usage: items enter on the in_ channel (operation and data_value) and
// results leave on the out_ channel, both under valid and stall.
// A push writes the shared store in the cycle it is taken, unless the
// store is full, and its result sits in the output register in the next
// cycle. A pop or drain of a non-empty stack reads the store, whose read
// data is registered, and its first result is loaded into the output
// register from the read state once the output is free. A drain then gives
// one result per cycle while the output is not stalled, top entry first,
// the last one marked. Pushes run at one item per cycle while the output is
// not stalled; during a pop or drain the block takes no new item until its
// last result is loaded, as the store's read data is registered. Operation
// codes six and seven are taken and give no result. Reset empties both
// stacks at once; the store itself is not cleared and needs no clearing pass.
// A waiting result is held under out_stall and the block takes no new item.
`timescale 1ns / 1ps
`include "two_stacks_shared_array_core_defines.svh"
module two_stacks_shared_array_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tssa_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tssa_pkg::out_item_t out_item
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t                           state_r, state_nxt;
  logic [tssa_pkg::CNT_W-1:0]       lower_r, lower_nxt;
  logic [tssa_pkg::CNT_W-1:0]       upper_r, upper_nxt;
  logic                             side_r, side_nxt;
  logic                             drain_r, drain_nxt;
  logic                             out_valid_r, out_valid_nxt;
  tssa_pkg::out_item_t              out_item_r, out_item_nxt;

  logic                             out_free;
  logic                             in_fire;
  logic                             full_now;
  logic [tssa_pkg::SUM_W-1:0]       count_sum;
  logic [tssa_pkg::SUM_W-1:0]       count_sum_nxt;
  logic [tssa_pkg::SUM_W-1:0]       flag_sum;
  logic                             load;
  logic                             side_in;
  logic [tssa_pkg::CNT_W-1:0]       cnt_sel;
  logic [tssa_pkg::CNT_W-1:0]       pop_addr_full;
  logic [tssa_pkg::CNT_W-1:0]       push_addr_full;

  logic                             wr_en;
  logic [tssa_pkg::ADDR_W-1:0]      wr_addr;
  logic                             rd_en;
  logic [tssa_pkg::ADDR_W-1:0]      rd_addr;
  logic [tssa_pkg::WORD_W-1:0]      rd_data;

  tssa_ram #(
    .WIDTH(tssa_pkg::WORD_W),
    .DEPTH(tssa_pkg::DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_item.data_value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign count_sum = {1'b0, lower_r} + {1'b0, upper_r};
  assign full_now  = (count_sum >= tssa_pkg::SUM_W'(tssa_pkg::DEPTH));

  always_comb begin
    side_in = (in_item.operation == tssa_pkg::OP_PUSH_TWO) ||
              (in_item.operation == tssa_pkg::OP_POP_TWO)  ||
              (in_item.operation == tssa_pkg::OP_DRAIN_TWO);
    if (state_r == S_IDLE) begin
      cnt_sel = side_in ? upper_r : lower_r;
    end else begin
      cnt_sel = side_r ? upper_r : lower_r;
    end
    if ((state_r == S_IDLE) ? side_in : side_r) begin
      pop_addr_full = tssa_pkg::CNT_W'(tssa_pkg::DEPTH) - upper_r;
    end else begin
      pop_addr_full = lower_r - tssa_pkg::CNT_W'(1);
    end
    push_addr_full = side_in ? (tssa_pkg::CNT_W'(tssa_pkg::DEPTH - 1) - upper_r) : lower_r;
  end

  always_comb begin
    state_nxt     = state_r;
    lower_nxt     = lower_r;
    upper_nxt     = upper_r;
    side_nxt      = side_r;
    drain_nxt     = drain_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    load          = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = push_addr_full[tssa_pkg::ADDR_W-1:0];
    rd_en         = 1'b0;
    rd_addr       = pop_addr_full[tssa_pkg::ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_item.operation)
            tssa_pkg::OP_PUSH_ONE, tssa_pkg::OP_PUSH_TWO: begin
              load = 1'b1;
              out_item_nxt.read_value  = '0;
              out_item_nxt.last_of_run = 1'b1;
              if (full_now) begin
                out_item_nxt.status_code = tssa_pkg::ST_OVERFLOW;
              end else begin
                out_item_nxt.status_code = tssa_pkg::ST_PUSH_DONE;
                wr_en = 1'b1;
                if (side_in) begin
                  upper_nxt = upper_r + tssa_pkg::CNT_W'(1);
                end else begin
                  lower_nxt = lower_r + tssa_pkg::CNT_W'(1);
                end
              end
            end
            tssa_pkg::OP_POP_ONE, tssa_pkg::OP_POP_TWO,
            tssa_pkg::OP_DRAIN_ONE, tssa_pkg::OP_DRAIN_TWO: begin
              if (cnt_sel == '0) begin
                load = 1'b1;
                out_item_nxt.read_value  = tssa_pkg::MINUS_ONE;
                out_item_nxt.status_code = tssa_pkg::ST_EMPTY;
                out_item_nxt.last_of_run = 1'b1;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_READ;
                side_nxt  = side_in;
                drain_nxt = (in_item.operation == tssa_pkg::OP_DRAIN_ONE) ||
                            (in_item.operation == tssa_pkg::OP_DRAIN_TWO);
                if (side_in) begin
                  upper_nxt = upper_r - tssa_pkg::CNT_W'(1);
                end else begin
                  lower_nxt = lower_r - tssa_pkg::CNT_W'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load = 1'b1;
          out_item_nxt.read_value  = rd_data;
          out_item_nxt.status_code = tssa_pkg::ST_POPPED;
          out_item_nxt.last_of_run = !drain_r || (cnt_sel == '0);
          if (drain_r && (cnt_sel != '0)) begin
            rd_en = 1'b1;
            if (side_r) begin
              upper_nxt = upper_r - tssa_pkg::CNT_W'(1);
            end else begin
              lower_nxt = lower_r - tssa_pkg::CNT_W'(1);
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    count_sum_nxt = {1'b0, lower_nxt} + {1'b0, upper_nxt};
    // A popped result reports the counts after its own pop, not after the next read of a drain.
    flag_sum      = (state_r == S_READ) ? count_sum : count_sum_nxt;
    if (load) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.store_full = (flag_sum >= tssa_pkg::SUM_W'(tssa_pkg::DEPTH));
      out_item_nxt.both_empty = (flag_sum == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lower_r     <= '0;
      upper_r     <= '0;
      side_r      <= 1'b0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lower_r     <= lower_nxt;
      upper_r     <= upper_nxt;
      side_r      <= side_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  `TSSA_ASSERT_NOW(a_count_bound, 1'b1, count_sum <= tssa_pkg::SUM_W'(tssa_pkg::DEPTH),
                   "stack counts exceed the store depth")
  `TSSA_ASSERT_NOW(a_full_not_empty, out_valid_r && out_item_r.store_full,
                   !out_item_r.both_empty, "result reports full and empty together")
  `TSSA_ASSERT_NEXT(a_read_delivers, state_r == S_READ && out_free,
                    out_valid_r && out_item_r.status_code == tssa_pkg::ST_POPPED,
                    "read data was not delivered")

endmodule
